>>> hdl/chained_hash_map_assert.svh
// assertion macros shared by the map modules
`ifndef CHAINED_HASH_MAP_ASSERT_SVH
`define CHAINED_HASH_MAP_ASSERT_SVH
// implication checked on every rising clock edge outside reset
`define CHM_ASSERT_IMP(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
// next-cycle implication checked outside reset
`define CHM_ASSERT_NXT(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`endif

>>> hdl/chm_pkg.sv
// shared types and constants of the chained hash map
package chm_pkg;
    localparam int BUCKETS_DEF     = 64;
    localparam int NODES_DEF       = 256;
    localparam int KEY_WIDTH_DEF   = 32;
    localparam int VALUE_WIDTH_DEF = 32;
    localparam int BC_WIDTH        = 7;
    localparam int CNT_WIDTH       = 9;
    localparam logic [BC_WIDTH-1:0] BC_RESET = 7'd64;

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_FIND   = 2'd1,
        CMD_REMOVE = 2'd2,
        CMD_CLEAR  = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NOTFOUND = 2'd1,
        ST_FULL     = 2'd2
    } t_status;

    typedef enum logic [3:0] {
        S_INIT, S_IDLE, S_MOD, S_HEAD, S_RD, S_CMP, S_ALLOC, S_POP, S_LINK,
        S_UNLINK, S_CLR, S_DONE
    } t_state;

    // controller to datapath commands
    typedef struct packed {
        logic load;      // latch item, start modulo
        logic mod_step;  // one restoring step of the modulo
        logic rd_head;   // read bucket head
        logic rd_node;   // read current node
        logic advance;   // prev <= cur, cur <= next
        logic upd_val;   // overwrite value of matching node
        logic pop_free;  // read top of free stack
        logic link_new;  // write new node and bucket head
        logic unlink;    // unlink found node and push free
        logic clr_step;  // clear one bucket head
        logic clr_regs;  // reset counters
        logic fin_ok;    // latch ok result with found value, zero for an update
        logic fin_nf;    // latch not found
        logic fin_full;  // latch pool full
        logic fin_plain; // latch ok result with zero value
    } t_ctl;

    // datapath to controller status
    typedef struct packed {
        logic mod_done;
        logic cur_nil;
        logic key_hit;
        logic guard_out;
        logic have_free;
        logic have_fresh;
        logic clr_done;
    } t_sts;
endpackage

>>> hdl/chm_ctrl.sv
// sequencing controller of the chained hash map
module chm_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  logic [1:0]      i_cmd,
    input  chm_pkg::t_sts   i_sts,
    output chm_pkg::t_ctl   o_ctl,
    output logic            o_busy,
    output logic            o_done
);
    chm_pkg::t_state r_state, n_state;
    logic [1:0]      r_cmd;

    // state and command register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= chm_pkg::S_INIT;
            r_cmd   <= 2'd0;
        end else begin
            r_state <= n_state;
            if (i_start && r_state == chm_pkg::S_IDLE) r_cmd <= i_cmd;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            chm_pkg::S_INIT: if (i_sts.clr_done) n_state = chm_pkg::S_IDLE;
            chm_pkg::S_IDLE: begin
                if (i_start) n_state = (i_cmd == chm_pkg::CMD_CLEAR) ? chm_pkg::S_CLR
                                                                      : chm_pkg::S_MOD;
            end
            chm_pkg::S_MOD:  if (i_sts.mod_done) n_state = chm_pkg::S_HEAD;
            chm_pkg::S_HEAD: n_state = chm_pkg::S_RD;
            chm_pkg::S_RD: begin
                if (i_sts.cur_nil || i_sts.guard_out) begin
                    if (r_cmd == chm_pkg::CMD_INSERT) n_state = chm_pkg::S_ALLOC;
                    else n_state = chm_pkg::S_DONE;
                end else n_state = chm_pkg::S_CMP;
            end
            chm_pkg::S_CMP: begin
                if (!i_sts.key_hit) n_state = chm_pkg::S_RD;
                else if (r_cmd == chm_pkg::CMD_REMOVE) n_state = chm_pkg::S_UNLINK;
                else n_state = chm_pkg::S_DONE;
            end
            chm_pkg::S_ALLOC: begin
                if (i_sts.have_free) n_state = chm_pkg::S_POP;
                else if (i_sts.have_fresh) n_state = chm_pkg::S_LINK;
                else n_state = chm_pkg::S_DONE;
            end
            chm_pkg::S_POP:    n_state = chm_pkg::S_LINK;
            chm_pkg::S_LINK:   n_state = chm_pkg::S_DONE;
            chm_pkg::S_UNLINK: n_state = chm_pkg::S_DONE;
            chm_pkg::S_CLR:    if (i_sts.clr_done) n_state = chm_pkg::S_DONE;
            chm_pkg::S_DONE:   n_state = chm_pkg::S_IDLE;
            default:           n_state = chm_pkg::S_IDLE;
        endcase
    end

    // command outputs
    always_comb begin
        o_ctl = '0;
        unique case (r_state)
            chm_pkg::S_INIT: o_ctl.clr_step = 1'b1;
            chm_pkg::S_IDLE: o_ctl.load = i_start;
            chm_pkg::S_MOD:  o_ctl.mod_step = !i_sts.mod_done;
            chm_pkg::S_HEAD: o_ctl.rd_head = 1'b1;
            chm_pkg::S_RD: begin
                o_ctl.rd_node = !(i_sts.cur_nil || i_sts.guard_out);
                if ((i_sts.cur_nil || i_sts.guard_out) && r_cmd != chm_pkg::CMD_INSERT)
                    o_ctl.fin_nf = 1'b1;
            end
            chm_pkg::S_CMP: begin
                if (!i_sts.key_hit) o_ctl.advance = 1'b1;
                else begin
                    o_ctl.fin_ok  = 1'b1;
                    o_ctl.upd_val = (r_cmd == chm_pkg::CMD_INSERT);
                    o_ctl.unlink  = (r_cmd == chm_pkg::CMD_REMOVE);
                end
            end
            chm_pkg::S_ALLOC: begin
                o_ctl.pop_free = i_sts.have_free;
                o_ctl.fin_full = !i_sts.have_free && !i_sts.have_fresh;
            end
            chm_pkg::S_LINK: begin
                o_ctl.link_new  = 1'b1;
                o_ctl.fin_plain = 1'b1;
            end
            chm_pkg::S_CLR: begin
                o_ctl.clr_step  = 1'b1;
                o_ctl.clr_regs  = 1'b1;
                o_ctl.fin_plain = 1'b1;
            end
            default: ;
        endcase
    end

    assign o_busy = (r_state != chm_pkg::S_IDLE);
    assign o_done = (r_state == chm_pkg::S_DONE);

    `include "chained_hash_map_assert.svh"
    `CHM_ASSERT_NXT(a_start_busy, i_clk, i_rst_n, i_start && !o_busy, o_busy)
    `CHM_ASSERT_NXT(a_done_idle, i_clk, i_rst_n, o_done, !o_busy)
    `CHM_ASSERT_IMP(a_one_fin, i_clk, i_rst_n, 1'b1, $onehot0({o_ctl.fin_ok, o_ctl.fin_nf, o_ctl.fin_full}))
endmodule

>>> hdl/chm_datapath.sv
// datapath of the chained hash map: modulo unit, memories, free stack, counters
module chm_datapath #(
    parameter int BUCKETS     = chm_pkg::BUCKETS_DEF,
    parameter int NODES       = chm_pkg::NODES_DEF,
    parameter int KEY_WIDTH   = chm_pkg::KEY_WIDTH_DEF,
    parameter int VALUE_WIDTH = chm_pkg::VALUE_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [chm_pkg::BC_WIDTH-1:0]  i_cfg_data,
    input  logic [KEY_WIDTH-1:0]          i_key,
    input  logic [VALUE_WIDTH-1:0]        i_value,
    input  chm_pkg::t_ctl                 i_ctl,
    output chm_pkg::t_sts                 o_sts,
    output logic [1:0]                    o_status,
    output logic [VALUE_WIDTH-1:0]        o_value_out,
    output logic [chm_pkg::CNT_WIDTH-1:0] o_entry_count
);
    localparam int BW  = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int NW  = $clog2(NODES);
    localparam int PW  = NW + 1;
    localparam int BCW = $clog2(BUCKETS + 1);
    localparam int MW  = (KEY_WIDTH > BCW) ? KEY_WIDTH : BCW;
    localparam int SW  = $clog2(KEY_WIDTH + 1);
    localparam logic [PW-1:0] NIL = PW'(NODES);

    logic [chm_pkg::BC_WIDTH-1:0] r_bc;
    logic [KEY_WIDTH-1:0]   r_key, r_quo;
    logic [VALUE_WIDTH-1:0] r_val;
    logic [MW:0]            r_rem;
    logic [BCW-1:0]         r_div;
    logic [SW-1:0]          r_mstep;
    logic [BW-1:0]          r_bucket;
    logic [PW-1:0]          r_cur, r_prev, r_new, r_cnext;
    logic [PW-1:0]          r_guard;
    logic [PW-1:0]          r_free_top, r_fresh;
    logic [chm_pkg::CNT_WIDTH-1:0] r_count;
    logic [BW-1:0]          r_clr_idx;
    logic [KEY_WIDTH-1:0]   r_nkey;
    logic [VALUE_WIDTH-1:0] r_nval;

    logic [PW-1:0]          m_head [BUCKETS];
    logic [KEY_WIDTH-1:0]   m_key  [NODES];
    logic [VALUE_WIDTH-1:0] m_value[NODES];
    logic [PW-1:0]          m_next [NODES];
    logic [NW-1:0]          m_free [NODES];

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_bc <= chm_pkg::BC_RESET;
        else if (i_cfg_we) r_bc <= i_cfg_data;
    end

    // clamped divisor
    logic [BCW-1:0] w_div;
    always_comb begin
        if (r_bc == '0) w_div = BCW'(1);
        else if (32'(r_bc) > BUCKETS) w_div = BCW'(BUCKETS);
        else w_div = BCW'(r_bc);
    end

    // restoring modulo, one quotient bit a cycle
    logic [MW:0] w_trial;
    assign w_trial = {r_rem[MW-1:0], r_quo[KEY_WIDTH-1]};
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_key   <= i_key;
            r_val   <= i_value;
            r_quo   <= i_key;
            r_rem   <= '0;
            r_div   <= w_div;
            r_mstep <= '0;
        end else if (i_ctl.mod_step) begin
            r_quo   <= r_quo << 1;
            r_mstep <= r_mstep + SW'(1);
            if (w_trial >= (MW+1)'(r_div)) r_rem <= w_trial - (MW+1)'(r_div);
            else r_rem <= w_trial;
        end
    end
    assign o_sts.mod_done = (32'(r_mstep) == KEY_WIDTH);

    // bucket head memory and clear sweep
    always_ff @(posedge i_clk) begin
        if (i_ctl.clr_step) m_head[r_clr_idx] <= NIL;
        else if (i_ctl.link_new) m_head[r_bucket] <= r_new;
        else if (i_ctl.unlink && r_prev == NIL) m_head[r_bucket] <= r_cnext;
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_clr_idx <= '0;
        else if (i_ctl.clr_step) r_clr_idx <= o_sts.clr_done ? '0 : r_clr_idx + BW'(1);
    end
    assign o_sts.clr_done = (32'(r_clr_idx) == BUCKETS - 1);

    // chain walk registers
    always_ff @(posedge i_clk) begin
        if (i_ctl.rd_head) begin
            r_bucket <= BW'(r_rem);
            r_cur    <= m_head[BW'(r_rem)];
            r_prev   <= NIL;
            r_guard  <= '0;
        end else if (i_ctl.advance) begin
            r_prev  <= r_cur;
            r_cur   <= r_cnext;
            r_guard <= r_guard + PW'(1);
        end
    end
    assign o_sts.cur_nil   = (r_cur >= NIL);
    assign o_sts.guard_out = (r_guard >= NIL);
    assign o_sts.key_hit   = (r_nkey == r_key);

    // node memories
    always_ff @(posedge i_clk) begin
        if (i_ctl.rd_node) begin
            r_nkey  <= m_key[r_cur[NW-1:0]];
            r_nval  <= m_value[r_cur[NW-1:0]];
            r_cnext <= m_next[r_cur[NW-1:0]];
        end
        if (i_ctl.link_new) begin
            m_key[r_new[NW-1:0]]   <= r_key;
            m_value[r_new[NW-1:0]] <= r_val;
            m_next[r_new[NW-1:0]]  <= m_head[r_bucket];
        end else if (i_ctl.upd_val) begin
            m_value[r_cur[NW-1:0]] <= r_val;
        end else if (i_ctl.unlink) begin
            if (r_prev != NIL) m_next[r_prev[NW-1:0]] <= r_cnext;
        end
    end

    // free stack, fresh mark and entry count
    assign o_sts.have_free  = (r_free_top != '0);
    assign o_sts.have_fresh = (r_fresh < NIL);
    always_ff @(posedge i_clk) begin
        if (i_ctl.pop_free) r_new <= PW'(m_free[NW'(r_free_top - PW'(1))]);
        else if (i_ctl.rd_head) r_new <= r_fresh;
        if (i_ctl.unlink) m_free[r_free_top[NW-1:0]] <= r_cur[NW-1:0];
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_free_top <= '0;
            r_fresh    <= '0;
            r_count    <= '0;
        end else if (i_ctl.clr_regs) begin
            r_free_top <= '0;
            r_fresh    <= '0;
            r_count    <= '0;
        end else begin
            if (i_ctl.pop_free) r_free_top <= r_free_top - PW'(1);
            if (i_ctl.link_new) begin
                r_count <= r_count + chm_pkg::CNT_WIDTH'(1);
                if (r_new == r_fresh) r_fresh <= r_fresh + PW'(1);
            end
            if (i_ctl.unlink) begin
                r_free_top <= r_free_top + PW'(1);
                if (r_count != '0) r_count <= r_count - chm_pkg::CNT_WIDTH'(1);
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (i_ctl.fin_ok) begin
            o_status    <= chm_pkg::ST_OK;
            o_value_out <= (i_ctl.upd_val) ? '0 : r_nval;
        end else if (i_ctl.fin_nf) begin
            o_status    <= chm_pkg::ST_NOTFOUND;
            o_value_out <= '0;
        end else if (i_ctl.fin_full) begin
            o_status    <= chm_pkg::ST_FULL;
            o_value_out <= '0;
        end else if (i_ctl.fin_plain) begin
            o_status    <= chm_pkg::ST_OK;
            o_value_out <= '0;
        end
    end
    assign o_entry_count = r_count;

    `include "chained_hash_map_assert.svh"
    `CHM_ASSERT_IMP(a_count_cap, i_clk, i_rst_n, 1'b1, 32'(r_count) <= NODES)
    `CHM_ASSERT_IMP(a_free_cap, i_clk, i_rst_n, 1'b1, r_free_top <= r_fresh)
    `CHM_ASSERT_IMP(a_rem_range, i_clk, i_rst_n, i_ctl.rd_head, r_rem < (MW+1)'(r_div))
endmodule

>>> hdl/chained_hash_map.sv
// top level of the chained hash map
// channel   | direction | signals
// command   | in        | start, i_cmd, i_key, i_value; busy is an output
// result    | out       | o_valid, o_status, o_value_out, o_entry_count, o_is_empty
// config    | in        | i_cfg_we, i_cfg_data
// a lookup runs the bit-serial modulo, one head read, then a node read and a
// compare per chain node visited, then the finish states up to the result;
// an insert of a new key takes the most
// clear sweeps the bucket head memory, one bucket a cycle, then gives a result
// synchronous active-low reset, then the same sweep with busy held high
// the result strobe o_valid lasts one cycle and cannot be stalled
module chained_hash_map #(
    parameter int BUCKETS     = chm_pkg::BUCKETS_DEF,
    parameter int NODES       = chm_pkg::NODES_DEF,
    parameter int KEY_WIDTH   = chm_pkg::KEY_WIDTH_DEF,
    parameter int VALUE_WIDTH = chm_pkg::VALUE_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [chm_pkg::BC_WIDTH-1:0]  i_cfg_data,
    input  logic                          start,
    output logic                          busy,
    input  logic [1:0]                    i_cmd,
    input  logic [KEY_WIDTH-1:0]          i_key,
    input  logic [VALUE_WIDTH-1:0]        i_value,
    output logic                          o_valid,
    output logic [1:0]                    o_status,
    output logic [VALUE_WIDTH-1:0]        o_value_out,
    output logic [chm_pkg::CNT_WIDTH-1:0] o_entry_count,
    output logic                          o_is_empty
);
    chm_pkg::t_ctl w_ctl;
    chm_pkg::t_sts w_sts;

    chm_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start), .i_cmd(i_cmd),
        .i_sts(w_sts), .o_ctl(w_ctl), .o_busy(busy), .o_done(o_valid)
    );

    chm_datapath #(
        .BUCKETS(BUCKETS), .NODES(NODES), .KEY_WIDTH(KEY_WIDTH),
        .VALUE_WIDTH(VALUE_WIDTH)
    ) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we),
        .i_cfg_data(i_cfg_data), .i_key(i_key), .i_value(i_value),
        .i_ctl(w_ctl), .o_sts(w_sts), .o_status(o_status),
        .o_value_out(o_value_out), .o_entry_count(o_entry_count)
    );

    assign o_is_empty = (o_entry_count == '0);
endmodule
